// ----- rtl/pid_clamped_sign_magnitude_assert.svh -----
// Assertion macros for the checker file.
`ifndef PID_CLAMPED_SIGN_MAGNITUDE_ASSERT_SVH
`define PID_CLAMPED_SIGN_MAGNITUDE_ASSERT_SVH

// Property checked on the rising clock edge, switched off while reset is low.
`define PCSM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on the rising clock edge, reset included.
`define PCSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pcsm_pkg.sv -----
`timescale 1ns / 1ps

package pcsm_pkg;

    // Default widths of the error sample and the integral accumulator
    localparam int ERROR_WIDTH_DEF = 16;
    localparam int ACCUM_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_RATE_LIMIT     = 3'd4,
        CFG_OUTPUT_LIMIT   = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [CFG_W-1:0] PROP_GAIN_RST      = 16'd256;
    localparam logic [CFG_W-1:0] INTEG_GAIN_RST     = 16'd0;
    localparam logic [CFG_W-1:0] DERIV_GAIN_RST     = 16'd0;
    localparam logic [CFG_W-1:0] INTEGRAL_LIMIT_RST = 16'd850;
    localparam logic [CFG_W-1:0] RATE_LIMIT_RST     = 16'd850;
    localparam logic [CFG_W-1:0] OUTPUT_LIMIT_RST   = 16'd90;

    // A symmetric clamp to a 16-bit limit fits in 17 signed bits
    localparam int CLAMP_W = CFG_W + 1;

    // Output magnitude and direction codes
    localparam int MAG_W = 16;
    localparam int DIR_W = 2;
    typedef logic signed [DIR_W-1:0] t_direction;
    localparam t_direction DIR_NONE = 2'sb00;
    localparam t_direction DIR_FWD  = 2'sb01;
    localparam t_direction DIR_BACK = 2'sb11;

    // Fraction bits of the Q8.8 gains
    localparam int FRAC_W = 8;

endpackage

// ----- rtl/pid_clamped_sign_magnitude.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                       Payload
// input     i_in_valid / o_in_ready         i_error_sample
// output    o_out_valid / i_out_ready       o_direction, o_magnitude
// config    i_cfg_wr_en (no handshake)      i_cfg_index, i_cfg_wdata
//
// One sample per clock while the output is not stalled: five register stages (state update,
// clamps, three parallel multipliers, sum, sign/magnitude) each hold one item.
// A result passes the stage 1-4 registers and the output register before o_out_valid.
// Synchronous active-low reset returns configuration registers, valid flags,
// integral and previous error to their reset values. Each stage holds only
// while the stages after it are full and the output is stalled, so bubbles are
// filled and an empty output register always lets a new sample in.
module pid_clamped_sign_magnitude #(
    parameter int ERROR_WIDTH = pcsm_pkg::ERROR_WIDTH_DEF,
    parameter int ACCUM_WIDTH = pcsm_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ERROR_WIDTH-1:0]       i_error_sample,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pcsm_pkg::t_direction                o_direction,
    output logic        [pcsm_pkg::MAG_W-1:0]   o_magnitude,
    // configuration writes
    input  logic                                i_cfg_wr_en,
    input  logic        [pcsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [pcsm_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import pcsm_pkg::*;

    localparam int SUM_W  = ((ACCUM_WIDTH > ERROR_WIDTH) ? ACCUM_WIDTH : ERROR_WIDTH) + 1;
    localparam int DIFF_W = ERROR_WIDTH + 1;
    localparam int PP_W   = CFG_W + ERROR_WIDTH;
    localparam int PI_W   = CFG_W + CLAMP_W;
    localparam int CORR_W = ((PP_W > PI_W) ? PP_W : PI_W) + 2;
    localparam int SHR_W  = CORR_W - FRAC_W;

    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'({1'b0, {(ACCUM_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

    // Configuration registers
    logic signed [CFG_W-1:0] r_prop_gain;
    logic signed [CFG_W-1:0] r_integ_gain;
    logic signed [CFG_W-1:0] r_deriv_gain;
    logic        [CFG_W-1:0] r_integral_limit;
    logic        [CFG_W-1:0] r_rate_limit;
    logic        [CFG_W-1:0] r_output_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= PROP_GAIN_RST;
            r_integ_gain     <= INTEG_GAIN_RST;
            r_deriv_gain     <= DERIV_GAIN_RST;
            r_integral_limit <= INTEGRAL_LIMIT_RST;
            r_rate_limit     <= RATE_LIMIT_RST;
            r_output_limit   <= OUTPUT_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:      r_prop_gain      <= $signed(i_cfg_wdata);
                CFG_INTEG_GAIN:     r_integ_gain     <= $signed(i_cfg_wdata);
                CFG_DERIV_GAIN:     r_deriv_gain     <= $signed(i_cfg_wdata);
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_wdata;
                CFG_RATE_LIMIT:     r_rate_limit     <= i_cfg_wdata;
                CFG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline valids and per-stage load enables
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic w_ld_out, w_ld4, w_ld3, w_ld2, w_ld1;
    logic w_in_xfer;

    assign w_ld_out   = !r_out_valid || i_out_ready;
    assign w_ld4      = !r_s4_valid || w_ld_out;
    assign w_ld3      = !r_s3_valid || w_ld4;
    assign w_ld2      = !r_s2_valid || w_ld3;
    assign w_ld1      = !r_s1_valid || w_ld2;
    assign w_in_xfer  = i_in_valid && w_ld1;
    assign o_in_ready = w_ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ld1)    r_s1_valid  <= i_in_valid;
            if (w_ld2)    r_s2_valid  <= r_s1_valid;
            if (w_ld3)    r_s3_valid  <= r_s2_valid;
            if (w_ld4)    r_s4_valid  <= r_s3_valid;
            if (w_ld_out) r_out_valid <= r_s4_valid;
        end
    end

    // Stage 1: saturating integral and difference, updated on each transfer
    logic signed [ACCUM_WIDTH-1:0] r_integral;
    logic signed [ERROR_WIDTH-1:0] r_prev_error;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [ACCUM_WIDTH-1:0] n_integral;
    logic signed [DIFF_W-1:0]      n_diff;

    always_comb begin
        n_sum = SUM_W'(r_integral) + SUM_W'(i_error_sample);
        if (n_sum > ACC_MAX) begin
            n_integral = ACC_MAX[ACCUM_WIDTH-1:0];
        end else if (n_sum < ACC_MIN) begin
            n_integral = ACC_MIN[ACCUM_WIDTH-1:0];
        end else begin
            n_integral = n_sum[ACCUM_WIDTH-1:0];
        end
        n_diff = DIFF_W'(i_error_sample) - DIFF_W'(r_prev_error);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_prev_error <= '0;
        end else if (w_in_xfer) begin
            r_integral   <= n_integral;
            r_prev_error <= i_error_sample;
        end
    end

    logic signed [ERROR_WIDTH-1:0] r_s1_error;
    logic signed [ACCUM_WIDTH-1:0] r_s1_integral;
    logic signed [DIFF_W-1:0]      r_s1_diff;

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1_error    <= i_error_sample;
            r_s1_integral <= n_integral;
            r_s1_diff     <= n_diff;
        end
    end

    // Stage 2: symmetric clamps
    logic signed [CLAMP_W-1:0] w_integ_clamp;
    logic signed [CLAMP_W-1:0] w_diff_clamp;

    pcsm_clamp #(.IN_W(ACCUM_WIDTH)) u_integ_clamp (
        .i_value (r_s1_integral),
        .i_limit (r_integral_limit),
        .o_value (w_integ_clamp)
    );

    pcsm_clamp #(.IN_W(DIFF_W)) u_diff_clamp (
        .i_value (r_s1_diff),
        .i_limit (r_rate_limit),
        .o_value (w_diff_clamp)
    );

    logic signed [ERROR_WIDTH-1:0] r_s2_error;
    logic signed [CLAMP_W-1:0]     r_s2_integ;
    logic signed [CLAMP_W-1:0]     r_s2_diff;

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2_error <= r_s1_error;
            r_s2_integ <= w_integ_clamp;
            r_s2_diff  <= w_diff_clamp;
        end
    end

    // Stage 3: the three gain products
    logic signed [PP_W-1:0] r_s3_pp;
    logic signed [PI_W-1:0] r_s3_pi;
    logic signed [PI_W-1:0] r_s3_pd;

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_s3_pp <= r_prop_gain * r_s2_error;
            r_s3_pi <= r_integ_gain * r_s2_integ;
            r_s3_pd <= r_deriv_gain * r_s2_diff;
        end
    end

    // Stage 4: correction sum in Q.8
    logic signed [CORR_W-1:0] r_s4_corr;

    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_s4_corr <= CORR_W'(r_s3_pp) + CORR_W'(r_s3_pi) + CORR_W'(r_s3_pd);
        end
    end

    // Stage 5: sign, absolute value, drop fraction, clamp to output limit
    logic [CORR_W-1:0]  n_abs;
    logic [SHR_W-1:0]   n_shr;
    t_direction         n_dir;
    logic [MAG_W-1:0]   n_mag;

    always_comb begin
        if (r_s4_corr[CORR_W-1]) begin
            n_abs = CORR_W'(-r_s4_corr);
            n_dir = DIR_BACK;
        end else if (r_s4_corr != '0) begin
            n_abs = CORR_W'(r_s4_corr);
            n_dir = DIR_FWD;
        end else begin
            n_abs = '0;
            n_dir = DIR_NONE;
        end
        n_shr = n_abs[CORR_W-1:FRAC_W];
        if (n_shr > SHR_W'(r_output_limit)) begin
            n_mag = r_output_limit;
        end else begin
            n_mag = n_shr[MAG_W-1:0];
        end
    end

    t_direction       r_direction;
    logic [MAG_W-1:0] r_magnitude;

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_direction <= n_dir;
            r_magnitude <= n_mag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_direction = r_direction;
    assign o_magnitude = r_magnitude;

endmodule

// ----- rtl/pcsm_clamp.sv -----
`timescale 1ns / 1ps

module pcsm_clamp #(
    parameter int IN_W = 17
) (
    input  logic signed [IN_W-1:0]               i_value,
    input  logic        [pcsm_pkg::CFG_W-1:0]    i_limit,
    output logic signed [pcsm_pkg::CLAMP_W-1:0]  o_value
);
    import pcsm_pkg::*;

    localparam int CMP_W = ((IN_W > CLAMP_W) ? IN_W : CLAMP_W) + 1;

    logic signed [CMP_W-1:0] w_value;
    logic signed [CMP_W-1:0] w_pos_lim;
    logic signed [CMP_W-1:0] w_neg_lim;

    assign w_value   = CMP_W'(i_value);
    assign w_pos_lim = CMP_W'($signed({1'b0, i_limit}));
    assign w_neg_lim = -w_pos_lim;

    // Symmetric clamp to +-limit; a zero limit gives zero
    always_comb begin
        if (w_value > w_pos_lim) begin
            o_value = w_pos_lim[CLAMP_W-1:0];
        end else if (w_value < w_neg_lim) begin
            o_value = w_neg_lim[CLAMP_W-1:0];
        end else begin
            o_value = w_value[CLAMP_W-1:0];
        end
    end

endmodule

// ----- rtl/pcsm_checker.sv -----
`timescale 1ns / 1ps

`include "pid_clamped_sign_magnitude_assert.svh"

module pcsm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input pcsm_pkg::t_direction              o_direction,
    input logic        [pcsm_pkg::MAG_W-1:0] o_magnitude
);
    import pcsm_pkg::*;

    // A stalled result keeps its value until the transfer
    `PCSM_ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_direction) && $stable(o_magnitude),
        "result changed while stalled")

    // No direction means a zero correction, hence a zero magnitude
    `PCSM_ASSERT_CLK(a_none_zero, i_clk, i_rst_n,
        o_out_valid && o_direction == DIR_NONE |-> o_magnitude == '0,
        "nonzero magnitude without direction")

    // With the output register empty the pipeline cannot be blocked
    `PCSM_ASSERT_CLK(a_ready_empty, i_clk, i_rst_n,
        !o_out_valid |-> o_in_ready,
        "input stalled while output empty")

    // Reset leaves no result pending
    `PCSM_ASSERT_ALWAYS(a_reset_empty, i_clk,
        $past(i_rst_n) == 1'b0 && $past(i_rst_n, 2) == 1'b0 |-> !o_out_valid,
        "result pending after reset")

endmodule

bind pid_clamped_sign_magnitude pcsm_checker u_pcsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_direction (o_direction),
    .o_magnitude (o_magnitude)
);
